FILE: rtl/core/efs_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the endpoint failover selector.
package efs_pkg;

    // operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_OFFLINE = 3'd1;
    localparam logic [2:0] OP_ONLINE  = 3'd2;
    localparam logic [2:0] OP_RESET   = 3'd3;
    localparam logic [2:0] OP_SELECT  = 3'd4;

    // balancing modes
    localparam logic [1:0] MODE_RANDOM = 2'd0;
    localparam logic [1:0] MODE_LOWEST = 2'd1;
    localparam logic [1:0] MODE_ROUND  = 2'd2;
    localparam logic [1:0] MODE_FIRST  = 2'd3;

    // result codes
    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_NO_HOST = 2'd1;
    localparam logic [1:0] RC_FULL    = 2'd2;
    localparam logic [1:0] RC_BAD_ID  = 2'd3;

    // entry status
    localparam logic [1:0] ST_UNKNOWN = 2'd0;
    localparam logic [1:0] ST_ONLINE  = 2'd1;
    localparam logic [1:0] ST_OFFLINE = 2'd2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  endpoint_id;
        logic [15:0] priority_req;
        logic [15:0] random_value;
    } t_efs_in;

    typedef struct packed {
        logic [1:0] status_code;
        logic [3:0] chosen_id;
        logic       fallback_lifetime;
        logic       better_exists;
        logic [4:0] endpoint_count;
        logic [4:0] available_count;
    } t_efs_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WRITE,
        S_CLEAR,
        S_SCAN,
        S_DIV,
        S_PICK,
        S_DONE
    } t_efs_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic write;
        logic clear;
        logic scan_init;
        logic scan;
        logic div_start;
        logic pick_init;
        logic pick;
        logic finish;
    } t_efs_cmd;

    // datapath -> controller
    typedef struct packed {
        logic go_write;
        logic go_clear;
        logic sweep_done;
        logic scan_done;
        logic need_pick;
        logic div_done;
    } t_efs_sts;

endpackage

FILE: rtl/core/efs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module efs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: rtl/core/efs_urem.sv
`timescale 1ns / 1ps
// Bit-serial unsigned remainder unit, one numerator bit per cycle.
module efs_urem #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_run;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W-1:0] n_rem;

    // shift in the next numerator bit, subtract when it fits
    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        if (trial >= {1'b0, r_den}) begin
            n_rem = DEN_W'(trial - {1'b0, r_den});
        end else begin
            n_rem = DEN_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_run) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/efs_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the endpoint failover selector.
module efs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  efs_pkg::t_efs_sts i_sts,
    output efs_pkg::t_efs_cmd o_cmd,
    output logic              o_busy
);

    import efs_pkg::*;

    t_efs_state r_state;
    t_efs_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.go_write) begin
                    n_state = S_WRITE;
                end else if (i_sts.go_clear) begin
                    n_state = S_CLEAR;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_WRITE: n_state = S_SCAN;
            S_CLEAR: begin
                if (i_sts.sweep_done) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = i_sts.need_pick ? S_DIV : S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_PICK;
            end
            S_PICK: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   o_cmd.load = i_start;
            S_DECODE: begin
                o_cmd.decode    = 1'b1;
                o_cmd.scan_init = 1'b1;
            end
            S_WRITE: begin
                o_cmd.write     = 1'b1;
                o_cmd.scan_init = 1'b1;
            end
            S_CLEAR: begin
                o_cmd.clear     = 1'b1;
                o_cmd.scan_init = i_sts.sweep_done;
            end
            S_SCAN: begin
                o_cmd.scan      = 1'b1;
                o_cmd.div_start = i_sts.scan_done && i_sts.need_pick;
            end
            S_DIV:  o_cmd.pick_init = i_sts.div_done;
            S_PICK: o_cmd.pick = 1'b1;
            S_DONE: o_cmd.finish = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/efs_dp.sv
`timescale 1ns / 1ps
// Datapath: entry tables, serial scan, selection logic and result register.
module efs_dp #(
    parameter int MAX_ENDPOINTS = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efs_pkg::t_efs_in  i_item,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  efs_pkg::t_efs_cmd i_cmd,
    output efs_pkg::t_efs_sts o_sts,
    output efs_pkg::t_efs_out o_res,
    output logic              o_res_strobe
);

    import efs_pkg::*;

    localparam int AW = $clog2(MAX_ENDPOINTS);
    localparam int CW = $clog2(MAX_ENDPOINTS + 1);
    localparam int XW = (CW > 4) ? CW : 4;
    localparam int PB = PRIORITY_BITS;

    // configuration and loaded item
    logic [1:0]    r_mode;
    logic [2:0]    r_op;
    logic [3:0]    r_eid;
    logic [PB-1:0] r_prio;
    logic [15:0]   r_rv;
    logic [1:0]    r_code;

    // table bookkeeping
    logic [CW-1:0] r_total;
    logic [PB-1:0] r_lowest;
    logic [AW-1:0] r_ptr;

    // scan pipeline
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic [1:0]    rd_s;
    logic [PB-1:0] rd_p;

    // scan results
    logic [CW-1:0] r_n_on, r_n_un;
    logic          r_bon_v, r_bun_v, r_fon_v, r_fun_v;
    logic [AW-1:0] r_bon_id, r_bun_id, r_fon_id, r_fun_id;
    logic [PB-1:0] r_bon_p, r_bun_p;
    logic [1:0]    r_ps, r_s0;

    // k-th match search
    logic [CW-1:0] r_kcnt;
    logic          r_pk_v;
    logic [AW-1:0] r_pk_id;
    logic [CW-1:0] k_rem;
    logic          div_done;

    t_efs_out r_res;
    logic     r_res_vld;

    // RAM ports
    logic          st_we, pr_we;
    logic [AW-1:0] st_wa;
    logic [1:0]    st_wd;

    logic          is_add, is_mark, full, bad, more;
    logic [XW-1:0] eid_x, tot_x;
    logic [AW-1:0] ptr_eff;
    logic [CW-1:0] avail, n_den;
    logic [1:0]    tgt;

    // selection outcome
    logic          sel_none, sel_pick, sel_fb, sel_adv;
    logic [AW-1:0] sel_id;
    logic [AW-1:0] ptr_next;
    t_efs_out      res_d;

    assign is_add  = (r_op == OP_ADD);
    assign is_mark = (r_op == OP_OFFLINE) || (r_op == OP_ONLINE);
    assign full    = (r_total == CW'(MAX_ENDPOINTS));
    assign eid_x   = XW'(r_eid);
    assign tot_x   = XW'(r_total);
    assign bad     = (eid_x >= tot_x);
    assign more    = (r_idx < r_total);
    assign ptr_eff = (CW'(r_ptr) >= r_total) ? '0 : r_ptr;
    assign avail   = r_n_on + r_n_un;
    assign n_den   = (r_n_on != '0) ? r_n_on : r_n_un;
    assign tgt     = (r_n_on != '0) ? ST_ONLINE : ST_UNKNOWN;

    assign o_sts.go_write   = (is_add && !full) || (is_mark && !bad);
    assign o_sts.go_clear   = (r_op == OP_RESET);
    assign o_sts.sweep_done = !more;
    assign o_sts.scan_done  = !more && !r_rd_vld;
    assign o_sts.need_pick  = (r_op == OP_SELECT) && sel_pick;
    assign o_sts.div_done   = div_done;

    // table writes: add, mark, or one row of the status clearing sweep
    always_comb begin
        st_we = 1'b0;
        pr_we = 1'b0;
        st_wa = r_idx[AW-1:0];
        st_wd = ST_UNKNOWN;
        if (i_cmd.write) begin
            st_we = 1'b1;
            if (is_add) begin
                pr_we = 1'b1;
                st_wa = r_total[AW-1:0];
            end else begin
                st_wa = AW'(r_eid);
                st_wd = (r_op == OP_OFFLINE) ? ST_OFFLINE : ST_ONLINE;
            end
        end else if (i_cmd.clear && more) begin
            st_we = 1'b1;
        end
    end

    efs_ram #(.WIDTH(2), .DEPTH(MAX_ENDPOINTS)) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_wa),
        .i_wdata (st_wd),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_s)
    );

    efs_ram #(.WIDTH(PB), .DEPTH(MAX_ENDPOINTS)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (pr_we),
        .i_waddr (r_total[AW-1:0]),
        .i_wdata (r_prio),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_p)
    );

    efs_urem #(.NUM_W(16), .DEN_W(CW)) u_urem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_rv),
        .i_den   (n_den),
        .o_done  (div_done),
        .o_rem   (k_rem)
    );

    // host choice from the scan results
    always_comb begin
        sel_none = 1'b0;
        sel_pick = 1'b0;
        sel_fb   = 1'b0;
        sel_adv  = 1'b0;
        sel_id   = '0;
        case (r_mode)
            MODE_RANDOM: begin
                if (avail == '0) sel_none = 1'b1;
                else sel_pick = 1'b1;
            end
            MODE_LOWEST: begin
                if (r_bon_v) begin
                    sel_id = r_bon_id;
                    sel_fb = (r_bon_p > r_lowest);
                end else if (r_bun_v) begin
                    sel_id = r_bun_id;
                    sel_fb = (r_bun_p > r_lowest);
                end else begin
                    sel_none = 1'b1;
                end
            end
            MODE_ROUND: begin
                if (r_ps == ST_ONLINE) begin
                    sel_id  = ptr_eff;
                    sel_adv = 1'b1;
                end else if (r_fon_v) begin
                    sel_id  = r_fon_id;
                    sel_adv = 1'b1;
                end else if (r_ps == ST_UNKNOWN) begin
                    sel_id = ptr_eff;
                end else if (r_fun_v) begin
                    sel_id  = r_fun_id;
                    sel_adv = 1'b1;
                end else begin
                    sel_none = 1'b1;
                end
            end
            default: begin
                if (r_s0 == ST_ONLINE) begin
                    sel_id = '0;
                end else if (r_n_on != '0) begin
                    sel_pick = 1'b1;
                    sel_fb   = 1'b1;
                end else if (r_s0 == ST_UNKNOWN) begin
                    sel_id = '0;
                end else if (r_n_un != '0) begin
                    sel_pick = 1'b1;
                    sel_fb   = 1'b1;
                end else begin
                    sel_none = 1'b1;
                end
            end
        endcase
        if (sel_pick) sel_id = r_pk_id;
        if (r_total == '0) begin
            sel_none = 1'b1;
            sel_pick = 1'b0;
            sel_fb   = 1'b0;
            sel_adv  = 1'b0;
        end
    end

    // pointer moves just past the chosen entry when the choice advances it, wrapping at the table end
    always_comb begin
        ptr_next = ptr_eff;
        if (!sel_none && sel_adv) begin
            if ((CW'(sel_id) + CW'(1)) == r_total) ptr_next = '0;
            else ptr_next = AW'(sel_id + 1'b1);
        end
    end

    always_comb begin
        res_d                 = '0;
        res_d.status_code     = r_code;
        res_d.endpoint_count  = 5'(r_total);
        res_d.available_count = 5'(avail);
        case (r_op)
            OP_ADD: begin
                if (r_code == RC_OK) res_d.chosen_id = 4'(r_total - 1'b1);
            end
            OP_ONLINE: begin
                if (r_code == RC_OK) begin
                    if (r_mode == MODE_LOWEST) begin
                        res_d.better_exists = r_bon_v && (r_bon_id != AW'(r_eid));
                    end else if (r_mode == MODE_FIRST) begin
                        res_d.better_exists = (r_s0 == ST_ONLINE) && (r_eid != 4'd0);
                    end
                end
            end
            OP_SELECT: begin
                if (sel_none) begin
                    res_d.status_code = RC_NO_HOST;
                end else begin
                    res_d.chosen_id         = 4'(sel_id);
                    res_d.fallback_lifetime = sel_fb;
                end
            end
            default: res_d.chosen_id = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_RANDOM;
            r_total   <= '0;
            r_lowest  <= '1;
            r_ptr     <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (i_cmd.write && is_add) begin
                r_total <= r_total + 1'b1;
                if (r_prio < r_lowest) r_lowest <= r_prio;
            end
            if (i_cmd.finish && (r_op == OP_SELECT) && (r_mode == MODE_ROUND) &&
                (r_total != '0)) begin
                r_ptr <= ptr_next;
            end
            if (i_cmd.scan_init || i_cmd.pick_init) begin
                r_idx <= '0;
            end else if ((i_cmd.clear || i_cmd.scan || i_cmd.pick) && more) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_vld  <= (i_cmd.scan || i_cmd.pick) && more;
            r_res_vld <= i_cmd.finish;
        end
    end

    // payload and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.operation;
            r_eid  <= i_item.endpoint_id;
            r_prio <= PB'(i_item.priority_req);
            r_rv   <= i_item.random_value;
        end
        if (i_cmd.decode) begin
            if (is_add && full) r_code <= RC_FULL;
            else if (is_mark && bad) r_code <= RC_BAD_ID;
            else r_code <= RC_OK;
        end
        r_rd_idx <= r_idx[AW-1:0];
        if (i_cmd.scan_init) begin
            r_n_on  <= '0;
            r_n_un  <= '0;
            r_bon_v <= 1'b0;
            r_bun_v <= 1'b0;
            r_fon_v <= 1'b0;
            r_fun_v <= 1'b0;
            r_ps    <= ST_OFFLINE;
            r_s0    <= ST_OFFLINE;
        end else if (i_cmd.scan && r_rd_vld) begin
            if (rd_s == ST_ONLINE) begin
                r_n_on <= r_n_on + 1'b1;
                if (!r_bon_v || (rd_p < r_bon_p)) begin
                    r_bon_v  <= 1'b1;
                    r_bon_id <= r_rd_idx;
                    r_bon_p  <= rd_p;
                end
                if (!r_fon_v) begin
                    r_fon_v  <= 1'b1;
                    r_fon_id <= r_rd_idx;
                end
            end else if (rd_s == ST_UNKNOWN) begin
                r_n_un <= r_n_un + 1'b1;
                if (!r_bun_v || (rd_p < r_bun_p)) begin
                    r_bun_v  <= 1'b1;
                    r_bun_id <= r_rd_idx;
                    r_bun_p  <= rd_p;
                end
                if (!r_fun_v) begin
                    r_fun_v  <= 1'b1;
                    r_fun_id <= r_rd_idx;
                end
            end
            if (r_rd_idx == ptr_eff) r_ps <= rd_s;
            if (r_rd_idx == '0) r_s0 <= rd_s;
        end
        if (i_cmd.pick_init) begin
            r_kcnt  <= '0;
            r_pk_v  <= 1'b0;
            r_pk_id <= '0;
        end else if (i_cmd.pick && r_rd_vld && (rd_s == tgt)) begin
            r_kcnt <= r_kcnt + 1'b1;
            if (!r_pk_v && (r_kcnt == k_rem)) begin
                r_pk_v  <= 1'b1;
                r_pk_id <= r_rd_idx;
            end
        end
        if (i_cmd.finish) r_res <= res_d;
    end

    assign o_res        = r_res;
    assign o_res_strobe = r_res_vld;

endmodule

FILE: rtl/core/endpoint_failover_selector.sv
`timescale 1ns / 1ps
// Top level of the endpoint failover selector: controller plus datapath.
//
//  channel  | direction | handshake                 | beat contents
//  ---------+-----------+---------------------------+---------------------------
//  item     | in        | start high, busy low      | i_item (operation, id, ...)
//  result   | out       | o_res_strobe, one cycle   | o_res (code, id, counts)
//  config   | in        | i_cfg_valid & o_cfg_ready | i_cfg_data (balancing mode)
//
// One item at a time. Each beat walks the table serially over the
// status/priority RAM read port; a reset first sweeps the status table, an
// add or mark first writes its entry, and picks in random mode or fallback
// picks in first mode add a bit-serial remainder and a second table walk.
// Reset is synchronous, active low; it empties the table (no clearing pass,
// entries at or above the fill count are never read). The result receiver
// cannot stall: each result beat is shown for exactly one cycle, and a new
// item may be taken in that same cycle. Configuration is taken while idle.
module endpoint_failover_selector #(
    parameter int MAX_ENDPOINTS = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  efs_pkg::t_efs_in  i_item,
    output logic              o_res_strobe,
    output efs_pkg::t_efs_out o_res,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_data
);

    import efs_pkg::*;

    t_efs_cmd cmd;
    t_efs_sts sts;

    // mode may only change between items
    assign o_cfg_ready = !busy;

    efs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    efs_dp #(
        .MAX_ENDPOINTS (MAX_ENDPOINTS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_res        (o_res),
        .o_res_strobe (o_res_strobe)
    );

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // a result beat only appears once the controller is back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> !busy)
        else $error("result strobe while busy");

    // one beat per item, never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("result strobe held for two cycles");

    // a full-table error only when the table is really full
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && (o_res.status_code == RC_FULL)) |->
            (o_res.endpoint_count == 5'(MAX_ENDPOINTS)))
        else $error("table full reported with spare entries");

endmodule
